FILE: rtl/irn_pkg.sv
// Package for the nearest-neighbor image rotation unit.
// Holds sizes, register and function codes, the queue entry and configuration types.
// No dependencies; every other file in rtl uses it by scoped names.
package irn_pkg;

	localparam int unsigned MAX_WIDTH   = 128;
	localparam int unsigned MAX_HEIGHT  = 128;
	localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
	localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned PIX_W    = 3 * SAMPLE_W;
	localparam int unsigned DIM_W    = 8;
	localparam int unsigned COEF_W   = 16;
	localparam int unsigned FRAC_W   = 14;

	// Offsets from the center fit in a signed word one bit wider than a dimension.
	localparam int unsigned DR_W   = DIM_W + 1;
	localparam int unsigned PROD_W = COEF_W + DR_W;
	localparam int unsigned SUM_W  = PROD_W + 1;
	localparam int unsigned SRC_W  = SUM_W - FRAC_W + 1;
	localparam int unsigned RND_BIAS = (1 << FRAC_W) - 1;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EMIT = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_COLOR  = 3'd2,
		REG_COS    = 3'd3,
		REG_SIN    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]         width;
		logic [DIM_W-1:0]         height;
		logic                     color;
		logic signed [COEF_W-1:0] cos_coeff;
		logic signed [COEF_W-1:0] sin_coeff;
	} cfg_t;

	typedef struct packed {
		logic              emit;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
	} q_entry_t;

	// A dimension register of zero acts as one; any value above the maximum acts as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
			input int unsigned maxv);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (int'(r) > int'(maxv)) begin
			d = DIM_W'(maxv);
		end else begin
			d = r;
		end
		return d;
	endfunction

endpackage

FILE: rtl/irn_if.sv
// Channel interfaces of the nearest-neighbor image rotation unit.
// Depends on irn_pkg for field widths.
interface irn_in_if;
	logic                            valid;
	logic                            ready;
	logic                            func;
	logic [irn_pkg::SAMPLE_W-1:0]    in_sample0;
	logic [irn_pkg::SAMPLE_W-1:0]    in_sample1;
	logic [irn_pkg::SAMPLE_W-1:0]    in_sample2;
	modport source(output valid, func, in_sample0, in_sample1, in_sample2, input ready);
	modport sink(input valid, func, in_sample0, in_sample1, in_sample2, output ready);
endinterface

interface irn_out_if;
	logic                            valid;
	logic                            ready;
	logic [irn_pkg::SAMPLE_W-1:0]    out_sample0;
	logic [irn_pkg::SAMPLE_W-1:0]    out_sample1;
	logic [irn_pkg::SAMPLE_W-1:0]    out_sample2;
	logic                            inside_res;
	logic                            frame_end;
	modport source(output valid, out_sample0, out_sample1, out_sample2, inside_res,
		frame_end, input ready);
	modport sink(input valid, out_sample0, out_sample1, out_sample2, inside_res,
		frame_end, output ready);
endinterface

interface irn_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [irn_pkg::CFG_IDX_W-1:0]     index;
	logic [irn_pkg::CFG_DATA_W-1:0]    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/image_rotate_nearest_unit.sv
// Top level of the nearest-neighbor image rotation unit: configuration registers,
// front end, entry queue and mapping back end. Depends on irn_pkg, irn_if,
// irn_front, irn_queue and irn_back.
//
//   channel   direction  fields                                          handshake
//   item      in         func, in_sample0..2                             valid/ready
//   result    out        out_sample0..2, inside_res, frame_end           valid/ready
//   cfg       in         index, data                                     valid/ready
//
// One word is taken per clock while the entry queue has room; every word, load or emit,
// makes one access to the single-port frame store, and that port sets the rate at one
// word per clock. An emit word passes through the queue, the mapping stages and the
// result register to the result channel. Reset clears the counters, the queue and the
// pipeline valids; the frame store is not cleared. A stall on the result side freezes
// the mapping pipeline, and the queue keeps accepting words until it holds four.
module image_rotate_nearest_unit (
	input  logic      clk,
	input  logic      arst_n,
	irn_in_if.sink    item,
	irn_out_if.source result,
	irn_cfg_if.sink   cfg
);

	// Raw register values as written; the effective values clamp the dimensions.
	logic [irn_pkg::DIM_W-1:0]          width_q;
	logic [irn_pkg::DIM_W-1:0]          height_q;
	logic                               color_q;
	logic signed [irn_pkg::COEF_W-1:0]  cos_q;
	logic signed [irn_pkg::COEF_W-1:0]  sin_q;
	irn_pkg::cfg_t                      cfg_eff;

	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	logic              q_full;
	irn_pkg::q_entry_t q_push_entry;
	irn_pkg::q_entry_t q_head;

	// The configuration port never stalls. The user must write only while the unit is idle; the block does not enforce it.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= irn_pkg::DIM_W'(128);
			height_q <= irn_pkg::DIM_W'(128);
			color_q  <= 1'b0;
			cos_q    <= irn_pkg::COEF_W'(16384);
			sin_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				irn_pkg::REG_WIDTH:  width_q  <= cfg.data[irn_pkg::DIM_W-1:0];
				irn_pkg::REG_HEIGHT: height_q <= cfg.data[irn_pkg::DIM_W-1:0];
				irn_pkg::REG_COLOR:  color_q  <= cfg.data[0];
				irn_pkg::REG_COS:    cos_q    <= cfg.data;
				irn_pkg::REG_SIN:    sin_q    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_eff.width     = irn_pkg::eff_dim(width_q, irn_pkg::MAX_WIDTH);
		cfg_eff.height    = irn_pkg::eff_dim(height_q, irn_pkg::MAX_HEIGHT);
		cfg_eff.color     = color_q;
		cfg_eff.cos_coeff = cos_q;
		cfg_eff.sin_coeff = sin_q;
	end

	// Front end: raster counters for loads and emits, one queue entry per word.
	irn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_eff (cfg_eff),
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_push_entry)
	);

	// Entry queue: decouples acceptance from the pipeline so either side can stall.
	irn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Back end: rotate about the center, bound check, store access, result register.
	// Loads and emits flow through the same stages, so store writes and reads keep
	// the order in which the words were accepted.
	irn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_eff (cfg_eff),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

FILE: rtl/irn_front.sv
// Front end: accepts words, keeps the load and output raster counters, builds queue entries.
// Depends on irn_pkg and irn_if.
module irn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  irn_pkg::cfg_t     cfg_eff,
	irn_in_if.sink            item,
	input  logic              q_full,
	output logic              q_push,
	output irn_pkg::q_entry_t q_entry
);

	localparam int unsigned TOT_W = 2 * irn_pkg::DIM_W;

	logic [irn_pkg::ADDR_W-1:0] lp_q;
	logic [irn_pkg::ROW_W-1:0]  row_q;
	logic [irn_pkg::COL_W-1:0]  col_q;

	logic [TOT_W-1:0]           total;
	logic [irn_pkg::ADDR_W-1:0] lp_eff;
	logic [irn_pkg::ADDR_W:0]   lp_inc;
	logic [irn_pkg::ADDR_W-1:0] lp_nx;
	logic [irn_pkg::ROW_W-1:0]  row_eff;
	logic [irn_pkg::COL_W-1:0]  col_eff;
	logic [irn_pkg::ROW_W:0]    row_inc;
	logic [irn_pkg::COL_W:0]    col_inc;
	logic [irn_pkg::ROW_W-1:0]  row_nx;
	logic [irn_pkg::COL_W-1:0]  col_nx;
	logic                       last;
	logic                       is_emit;

	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full;
	assign is_emit    = (item.func == irn_pkg::FUNC_EMIT);

	always_comb begin
		total  = TOT_W'(cfg_eff.width) * TOT_W'(cfg_eff.height);
		lp_eff = (32'(lp_q) >= 32'(total)) ? '0 : lp_q;
		lp_inc = (irn_pkg::ADDR_W + 1)'(lp_eff) + 1'b1;
		lp_nx  = (32'(lp_inc) >= 32'(total)) ? '0 : lp_inc[irn_pkg::ADDR_W-1:0];

		if (32'(row_q) >= 32'(cfg_eff.height) || 32'(col_q) >= 32'(cfg_eff.width)) begin
			row_eff = '0;
			col_eff = '0;
		end else begin
			row_eff = row_q;
			col_eff = col_q;
		end
		last = (32'(row_eff) == 32'(cfg_eff.height) - 32'd1) &&
			(32'(col_eff) == 32'(cfg_eff.width) - 32'd1);

		col_inc = (irn_pkg::COL_W + 1)'(col_eff) + 1'b1;
		row_inc = (irn_pkg::ROW_W + 1)'(row_eff) + 1'b1;
		if (32'(col_inc) >= 32'(cfg_eff.width)) begin
			col_nx = '0;
			row_nx = (32'(row_inc) >= 32'(cfg_eff.height)) ? '0 :
				row_inc[irn_pkg::ROW_W-1:0];
		end else begin
			col_nx = col_inc[irn_pkg::COL_W-1:0];
			row_nx = row_eff;
		end

		q_entry.emit = is_emit;
		q_entry.row  = row_eff;
		q_entry.col  = col_eff;
		q_entry.last = last;
		q_entry.addr = lp_eff;
		q_entry.pix  = {item.in_sample2, item.in_sample1, item.in_sample0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (q_push) begin
			if (is_emit) begin
				row_q <= row_nx;
				col_q <= col_nx;
			end else begin
				lp_q <= lp_nx;
			end
		end
	end

endmodule

FILE: rtl/irn_queue.sv
// Short queue between the front end and the mapping pipeline.
// Depends on irn_pkg for the entry type and depth.
module irn_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irn_pkg::q_entry_t push_entry,
	input  logic              pop,
	output irn_pkg::q_entry_t head,
	output logic              empty,
	output logic              full
);

	irn_pkg::q_entry_t          slot_q [irn_pkg::QUEUE_DEPTH];
	logic [irn_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [irn_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [irn_pkg::QPTR_W:0]   count_q;
	logic                       do_pop;

	assign empty  = (count_q == '0);
	assign full   = (32'(count_q) == irn_pkg::QUEUE_DEPTH);
	assign head   = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (irn_pkg::QPTR_W + 1)'(push && !full)
				- (irn_pkg::QPTR_W + 1)'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= irn_pkg::QUEUE_DEPTH)
		else $error("queue count above depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

FILE: rtl/irn_back.sv
// Back end: coordinate mapping pipeline, frame store and output register.
// Depends on irn_pkg and irn_if.
module irn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  irn_pkg::cfg_t     cfg_eff,
	input  irn_pkg::q_entry_t head,
	input  logic              q_empty,
	output logic              q_pop,
	irn_out_if.source         result
);

	logic [irn_pkg::PIX_W-1:0] store_mem [irn_pkg::STORE_DEPTH];

	logic                       adv;
	logic [irn_pkg::DIM_W-1:0]  crow;
	logic [irn_pkg::DIM_W-1:0]  ccol;

	// Stage 1: offsets from the center.
	logic                             v_s1, emit_s1, last_s1;
	logic signed [irn_pkg::DR_W-1:0]  dr_s1, dc_s1;
	logic [irn_pkg::ADDR_W-1:0]       addr_s1;
	logic [irn_pkg::PIX_W-1:0]        pix_s1;
	// Stage 2: the four products.
	logic                             v_s2, emit_s2, last_s2;
	logic signed [irn_pkg::PROD_W-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic [irn_pkg::ADDR_W-1:0]       addr_s2;
	logic [irn_pkg::PIX_W-1:0]        pix_s2;
	// Stage 3: source coordinates.
	logic                             v_s3, emit_s3, last_s3;
	logic signed [irn_pkg::SRC_W-1:0] src_r_s3, src_c_s3;
	logic [irn_pkg::ADDR_W-1:0]       addr_s3;
	logic [irn_pkg::PIX_W-1:0]        pix_s3;
	// Stage 4: bounds and store address.
	logic                             v_s4, emit_s4, last_s4, inside_s4;
	logic [irn_pkg::ADDR_W-1:0]       addr_s4;
	logic [irn_pkg::PIX_W-1:0]        pix_s4;
	// Stage 5: store access.
	logic                             v_s5, emit_s5, last_s5, inside_s5;
	logic [irn_pkg::PIX_W-1:0]        rd_s5;

	logic                             res_valid_q;
	logic [irn_pkg::SAMPLE_W-1:0]     res_s0_q, res_s1_q, res_s2_q;
	logic                             res_inside_q, res_last_q;

	logic signed [irn_pkg::SUM_W-1:0] sum_r, sum_c, bias_r, bias_c;
	logic signed [irn_pkg::SRC_W-1:0] q_r, q_c;
	logic                             in_frame;
	logic [irn_pkg::ROW_W+irn_pkg::DIM_W-1:0] row_base;
	logic [irn_pkg::ADDR_W-1:0]       map_addr;

	assign crow  = cfg_eff.height >> 1;
	assign ccol  = cfg_eff.width >> 1;
	assign adv   = !res_valid_q || result.ready;
	assign q_pop = adv && !q_empty;

	always_comb begin
		sum_r  = irn_pkg::SUM_W'(pa_s2) - irn_pkg::SUM_W'(pb_s2);
		sum_c  = irn_pkg::SUM_W'(pc_s2) + irn_pkg::SUM_W'(pd_s2);
		// Arithmetic shift rounds down, so negative sums get a bias to round toward zero.
		bias_r = sum_r + (sum_r[irn_pkg::SUM_W-1] ?
			irn_pkg::SUM_W'(irn_pkg::RND_BIAS) : irn_pkg::SUM_W'(0));
		bias_c = sum_c + (sum_c[irn_pkg::SUM_W-1] ?
			irn_pkg::SUM_W'(irn_pkg::RND_BIAS) : irn_pkg::SUM_W'(0));
		q_r = irn_pkg::SRC_W'(bias_r >>> irn_pkg::FRAC_W);
		q_c = irn_pkg::SRC_W'(bias_c >>> irn_pkg::FRAC_W);

		in_frame = !src_r_s3[irn_pkg::SRC_W-1] && !src_c_s3[irn_pkg::SRC_W-1] &&
			(src_r_s3 < $signed(irn_pkg::SRC_W'(cfg_eff.height))) &&
			(src_c_s3 < $signed(irn_pkg::SRC_W'(cfg_eff.width)));
		row_base = (irn_pkg::ROW_W + irn_pkg::DIM_W)'(src_r_s3[irn_pkg::ROW_W-1:0]) *
			(irn_pkg::ROW_W + irn_pkg::DIM_W)'(cfg_eff.width);
		map_addr = row_base[irn_pkg::ADDR_W-1:0] +
			irn_pkg::ADDR_W'(src_c_s3[irn_pkg::COL_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			res_valid_q <= v_s5 && emit_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s1 <= head.emit;
			last_s1 <= head.last;
			addr_s1 <= head.addr;
			pix_s1  <= head.pix;
			dr_s1   <= $signed(irn_pkg::DR_W'(head.row)) - $signed(irn_pkg::DR_W'(crow));
			dc_s1   <= $signed(irn_pkg::DR_W'(head.col)) - $signed(irn_pkg::DR_W'(ccol));

			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			addr_s2 <= addr_s1;
			pix_s2  <= pix_s1;
			pa_s2   <= cfg_eff.cos_coeff * dr_s1;
			pb_s2   <= cfg_eff.sin_coeff * dc_s1;
			pc_s2   <= cfg_eff.sin_coeff * dr_s1;
			pd_s2   <= cfg_eff.cos_coeff * dc_s1;

			emit_s3  <= emit_s2;
			last_s3  <= last_s2;
			addr_s3  <= addr_s2;
			pix_s3   <= pix_s2;
			src_r_s3 <= q_r + $signed(irn_pkg::SRC_W'(crow));
			src_c_s3 <= q_c + $signed(irn_pkg::SRC_W'(ccol));

			emit_s4   <= emit_s3;
			last_s4   <= last_s3;
			pix_s4    <= pix_s3;
			inside_s4 <= in_frame;
			addr_s4   <= emit_s3 ? map_addr : addr_s3;

			emit_s5   <= emit_s4;
			last_s5   <= last_s4;
			inside_s5 <= inside_s4;

			res_s0_q     <= inside_s5 ? rd_s5[irn_pkg::SAMPLE_W-1:0] : '0;
			res_s1_q     <= (inside_s5 && cfg_eff.color) ?
				rd_s5[2*irn_pkg::SAMPLE_W-1:irn_pkg::SAMPLE_W] : '0;
			res_s2_q     <= (inside_s5 && cfg_eff.color) ?
				rd_s5[3*irn_pkg::SAMPLE_W-1:2*irn_pkg::SAMPLE_W] : '0;
			res_inside_q <= inside_s5;
			res_last_q   <= last_s5;
		end
	end

	// Single-port frame store: a load writes, an emit reads, one access per stage slot.
	always_ff @(posedge clk) begin
		if (adv && v_s4 && !emit_s4) begin
			store_mem[addr_s4] <= pix_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s5 <= store_mem[addr_s4];
		end
	end

	assign result.valid       = res_valid_q;
	assign result.out_sample0 = res_s0_q;
	assign result.out_sample1 = res_s1_q;
	assign result.out_sample2 = res_s2_q;
	assign result.inside_res  = res_inside_q;
	assign result.frame_end   = res_last_q;

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s5 && emit_s5) |=> res_valid_q)
		else $error("emit word lost before the output register");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> ($stable(v_s1) && $stable(v_s5)))
		else $error("pipeline moved during an output stall");

endmodule
